### hdl/led_strip_pixel_store_core_defines.svh
// Assertion macros shared by the pixel store modules.
`ifndef LED_STRIP_PIXEL_STORE_CORE_DEFINES_SVH
`define LED_STRIP_PIXEL_STORE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define LSPS_ASSERT_IMP(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("pixel store assertion failed");
`define LSPS_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("pixel store assertion failed");
`else
`define LSPS_ASSERT_IMP(label, cond, prop)
`define LSPS_ASSERT_NEXT(label, cond, prop)
`endif
`endif

### hdl/lsps_pkg.sv
// Types and constants shared by the pixel store modules.
package lsps_pkg;

   localparam int BYTE_W      = 8;
   localparam int PIXEL_W     = 3 * BYTE_W;
   localparam int FUNC_W      = 3;
   localparam int INDEX_W     = 8;
   localparam int STEPS_W     = 9;
   localparam int COUNT_W     = 9;
   localparam int CFG_INDEX_W = 1;
   localparam int CFG_DATA_W  = 9;

   typedef enum logic [CFG_INDEX_W-1:0] {
      CSR_PIXEL_COUNT = 1'b0,
      CSR_GRB_ORDER   = 1'b1
   } csr_index_type;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_SET   = 3'd0,
      FUNC_GET   = 3'd1,
      FUNC_CLEAR = 3'd2,
      FUNC_ROTL  = 3'd3,
      FUNC_ROTR  = 3'd4,
      FUNC_SHL   = 3'd5,
      FUNC_SHR   = 3'd6
   } func_type;

   typedef enum logic [2:0] {
      ST_CLEAR_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_CLEAR_OP,
      ST_ROT_CAPTURE,
      ST_MOVE_READ,
      ST_MOVE_WRITE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic set_write;
      logic get_read;
      logic clr_start;
      logic clr_step;
      logic rot_read;
      logic rot_capture;
      logic shift_init;
      logic move_read;
      logic move_write;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              index_bad;
      logic              steps_bad;
      logic              count_zero;
      logic              clr_last;
      logic              move_last;
   } stat_type;

endpackage

### hdl/lsps_if.sv
// Request and response channel interfaces of the pixel store.
interface lsps_req_if;
   logic                           valid;
   logic                           ready;
   logic [lsps_pkg::FUNC_W-1:0]    func;
   logic [lsps_pkg::INDEX_W-1:0]   pixel_index;
   logic [lsps_pkg::STEPS_W-1:0]   shift_steps;
   logic [lsps_pkg::BYTE_W-1:0]    red_in;
   logic [lsps_pkg::BYTE_W-1:0]    green_in;
   logic [lsps_pkg::BYTE_W-1:0]    blue_in;

   modport source (output valid, func, pixel_index, shift_steps, red_in, green_in, blue_in,
                   input ready);
   modport sink (input valid, func, pixel_index, shift_steps, red_in, green_in, blue_in,
                 output ready);
endinterface

interface lsps_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        status;
   logic [lsps_pkg::BYTE_W-1:0] first_byte;
   logic [lsps_pkg::BYTE_W-1:0] second_byte;
   logic [lsps_pkg::BYTE_W-1:0] third_byte;

   modport source (output valid, status, first_byte, second_byte, third_byte, input ready);
   modport sink (input valid, status, first_byte, second_byte, third_byte, output ready);
endinterface

### hdl/led_strip_pixel_store_core.sv
// Top level of the LED strip pixel store.
//
//   channel   direction  transaction
//   req_chan  in         one operation: func, index, steps, colour
//   rsp_chan  out        one result: status and three wire bytes
//   csr_*     in         register write: pixel count, GRB order
//
// Set, get, unused codes, rotates with a zero count and failed shifts go from decode
// straight to the final state; clear writes zero to all MAX_PIXELS entries. Rotate and
// shift move the n active pixels one at a time, n being the active count, each move a
// read and then a write through the single read and single write port of the pixel memory.
// After reset a clearing pass over all MAX_PIXELS entries runs before the first request.
// A new request is taken while the previous result still waits in the output
// register; a stalled result holds the sequencer in its final state.
module led_strip_pixel_store_core #(
   parameter int MAX_PIXELS = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   lsps_req_if.sink                          req_chan,
   lsps_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [lsps_pkg::CFG_INDEX_W-1:0]  csr_index,
   input  logic [lsps_pkg::CFG_DATA_W-1:0]   csr_wdata
);
   import lsps_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   lsps_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lsps_datapath #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_func        (req_chan.func),
      .req_pixel_index (req_chan.pixel_index),
      .req_shift_steps (req_chan.shift_steps),
      .req_red_in      (req_chan.red_in),
      .req_green_in    (req_chan.green_in),
      .req_blue_in     (req_chan.blue_in),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_status      (rsp_chan.status),
      .rsp_first_byte  (rsp_chan.first_byte),
      .rsp_second_byte (rsp_chan.second_byte),
      .rsp_third_byte  (rsp_chan.third_byte)
   );

endmodule

### hdl/lsps_datapath.sv
// Pixel memory, configuration registers, move counter and response register.
`include "led_strip_pixel_store_core_defines.svh"
module lsps_datapath #(
   parameter int MAX_PIXELS = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [lsps_pkg::CFG_INDEX_W-1:0]  csr_index,
   input  logic [lsps_pkg::CFG_DATA_W-1:0]   csr_wdata,
   input  logic [lsps_pkg::FUNC_W-1:0]       req_func,
   input  logic [lsps_pkg::INDEX_W-1:0]      req_pixel_index,
   input  logic [lsps_pkg::STEPS_W-1:0]      req_shift_steps,
   input  logic [lsps_pkg::BYTE_W-1:0]       req_red_in,
   input  logic [lsps_pkg::BYTE_W-1:0]       req_green_in,
   input  logic [lsps_pkg::BYTE_W-1:0]       req_blue_in,
   input  lsps_pkg::cmd_type                 cmd,
   output lsps_pkg::stat_type                stat,
   output logic                              rsp_status,
   output logic [lsps_pkg::BYTE_W-1:0]       rsp_first_byte,
   output logic [lsps_pkg::BYTE_W-1:0]       rsp_second_byte,
   output logic [lsps_pkg::BYTE_W-1:0]       rsp_third_byte
);
   import lsps_pkg::*;

   localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int CW = $clog2(MAX_PIXELS + 1);
   localparam int NW = (CW > COUNT_W) ? CW : COUNT_W;
   localparam logic [NW-1:0] MAX_N = NW'(MAX_PIXELS);

   logic [PIXEL_W-1:0] mem [MAX_PIXELS];

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               grb_ff, grb_in;
   logic [FUNC_W-1:0]  func_ff;
   logic [INDEX_W-1:0] idx_ff;
   logic [STEPS_W-1:0] steps_ff;
   logic [BYTE_W-1:0]  red_ff, green_ff, blue_ff;
   logic [NW-1:0]      i_ff, i_in;
   logic               use_src_ff;
   logic [PIXEL_W-1:0] fill_ff;
   logic [PIXEL_W-1:0] rd_data_ff;
   logic               status_ff;
   logic [PIXEL_W-1:0] rsp_data_ff;

   logic [NW-1:0]      count_ext, n, n_minus1, idx_ext, steps_ext, s_eff, diff;
   logic [NW:0]        sum;
   logic               is_left, is_rot, is_shift, is_index_op;
   logic               use_src;
   logic [AW-1:0]      src_addr;
   logic               mem_we, rd_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [PIXEL_W-1:0] wr_data;
   logic               bad;

   assign count_ext   = NW'(count_ff);
   assign n           = (count_ext > MAX_N) ? MAX_N : count_ext;
   assign n_minus1    = n - NW'(1);
   assign idx_ext     = NW'(idx_ff);
   assign steps_ext   = NW'(steps_ff);
   assign is_left     = (func_ff == FUNC_ROTL) || (func_ff == FUNC_SHL);
   assign is_rot      = (func_ff == FUNC_ROTL) || (func_ff == FUNC_ROTR);
   assign is_shift    = (func_ff == FUNC_SHL) || (func_ff == FUNC_SHR);
   assign is_index_op = (func_ff == FUNC_SET) || (func_ff == FUNC_GET);
   assign s_eff       = is_rot ? NW'(1) : steps_ext;
   assign sum         = {1'b0, i_ff} + {1'b0, s_eff};
   assign diff        = i_ff - s_eff;
   assign use_src     = is_left ? (sum < {1'b0, n}) : (i_ff >= s_eff);
   assign src_addr    = is_left ? sum[AW-1:0] : diff[AW-1:0];

   assign stat.func       = func_ff;
   assign stat.index_bad  = (idx_ext >= n);
   assign stat.steps_bad  = (steps_ff == '0) || (steps_ext > n);
   assign stat.count_zero = (n == '0);
   assign stat.clr_last   = (i_ff == MAX_N - NW'(1));
   assign stat.move_last  = is_left ? (i_ff == n_minus1) : (i_ff == '0);

   assign bad = (is_index_op && stat.index_bad) || (is_shift && stat.steps_bad);

   always_comb begin
      count_in = count_ff;
      grb_in   = grb_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PIXEL_COUNT: count_in = csr_wdata[COUNT_W-1:0];
            CSR_GRB_ORDER:   grb_in   = csr_wdata[0];
            default:         count_in = count_ff;
         endcase
      end
   end

   always_comb begin
      i_in = i_ff;
      if (cmd.clr_start) begin
         i_in = '0;
      end else if (cmd.clr_step) begin
         i_in = i_ff + NW'(1);
      end else if (cmd.shift_init || cmd.rot_capture) begin
         i_in = is_left ? '0 : n_minus1;
      end else if (cmd.move_write) begin
         i_in = is_left ? (i_ff + NW'(1)) : (i_ff - NW'(1));
      end
   end

   always_comb begin
      mem_we  = cmd.set_write || cmd.clr_step || cmd.move_write;
      wr_addr = cmd.set_write ? idx_ext[AW-1:0] : i_ff[AW-1:0];
      if (cmd.set_write) begin
         wr_data = grb_ff ? {green_ff, red_ff, blue_ff} : {red_ff, green_ff, blue_ff};
      end else if (cmd.move_write) begin
         wr_data = use_src_ff ? rd_data_ff : fill_ff;
      end else begin
         wr_data = '0;
      end
      rd_en = cmd.get_read || cmd.rot_read || cmd.move_read;
      if (cmd.get_read) begin
         rd_addr = idx_ext[AW-1:0];
      end else if (cmd.rot_read) begin
         rd_addr = is_left ? '0 : n_minus1[AW-1:0];
      end else begin
         rd_addr = src_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         grb_ff   <= 1'b1;
         i_ff     <= '0;
      end else begin
         count_ff <= count_in;
         grb_ff   <= grb_in;
         i_ff     <= i_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         idx_ff   <= req_pixel_index;
         steps_ff <= req_shift_steps;
         red_ff   <= req_red_in;
         green_ff <= req_green_in;
         blue_ff  <= req_blue_in;
      end
      if (cmd.move_read) begin
         use_src_ff <= use_src;
      end
      if (cmd.shift_init) begin
         fill_ff <= {red_ff, green_ff, blue_ff};
      end else if (cmd.rot_capture) begin
         fill_ff <= rd_data_ff;
      end
      if (cmd.rsp_load) begin
         status_ff   <= bad;
         rsp_data_ff <= ((func_ff == FUNC_GET) && !stat.index_bad) ? rd_data_ff : '0;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_first_byte  = rsp_data_ff[PIXEL_W-1 -: BYTE_W];
   assign rsp_second_byte = rsp_data_ff[BYTE_W +: BYTE_W];
   assign rsp_third_byte  = rsp_data_ff[BYTE_W-1:0];

   `LSPS_ASSERT_IMP(a_move_in_range, cmd.move_write, i_ff < n)
   `LSPS_ASSERT_IMP(a_rd_hold, cmd.rsp_load, !rd_en)

endmodule

### hdl/lsps_controller.sv
// Sequencer that steps the pixel store through each operation.
`include "led_strip_pixel_store_core_defines.svh"
module lsps_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  lsps_pkg::stat_type  stat,
   output lsps_pkg::cmd_type   cmd
);
   import lsps_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_fire, rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR_INIT:  state_in = stat.clr_last ? ST_IDLE : ST_CLEAR_INIT;
         ST_IDLE:        state_in = req_fire ? ST_DECODE : ST_IDLE;
         ST_DECODE: begin
            unique case (stat.func) inside
               FUNC_CLEAR:           state_in = ST_CLEAR_OP;
               FUNC_ROTL, FUNC_ROTR: state_in = stat.count_zero ? ST_FINISH : ST_ROT_CAPTURE;
               FUNC_SHL, FUNC_SHR:   state_in = stat.steps_bad ? ST_FINISH : ST_MOVE_READ;
               default:              state_in = ST_FINISH;
            endcase
         end
         ST_CLEAR_OP:    state_in = stat.clr_last ? ST_FINISH : ST_CLEAR_OP;
         ST_ROT_CAPTURE: state_in = ST_MOVE_READ;
         ST_MOVE_READ:   state_in = ST_MOVE_WRITE;
         ST_MOVE_WRITE:  state_in = stat.move_last ? ST_FINISH : ST_MOVE_READ;
         ST_FINISH:      state_in = rsp_free ? ST_IDLE : ST_FINISH;
         default:        state_in = ST_CLEAR_INIT;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.capture = req_fire;
      unique case (state_ff)
         ST_CLEAR_INIT: cmd.clr_step = 1'b1;
         ST_DECODE: begin
            cmd.set_write  = (stat.func == FUNC_SET) && !stat.index_bad;
            cmd.get_read   = (stat.func == FUNC_GET) && !stat.index_bad;
            cmd.clr_start  = (stat.func == FUNC_CLEAR);
            cmd.rot_read   = ((stat.func == FUNC_ROTL) || (stat.func == FUNC_ROTR))
                             && !stat.count_zero;
            cmd.shift_init = ((stat.func == FUNC_SHL) || (stat.func == FUNC_SHR))
                             && !stat.steps_bad;
         end
         ST_CLEAR_OP:    cmd.clr_step    = 1'b1;
         ST_ROT_CAPTURE: cmd.rot_capture = 1'b1;
         ST_MOVE_READ:   cmd.move_read   = 1'b1;
         ST_MOVE_WRITE:  cmd.move_write  = 1'b1;
         ST_FINISH:      cmd.rsp_load    = rsp_free;
         default:        cmd.capture     = req_fire;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `LSPS_ASSERT_NEXT(a_fire_decode, req_fire, state_ff == ST_DECODE)
   `LSPS_ASSERT_IMP(a_init_quiet, state_ff == ST_CLEAR_INIT, !rsp_valid_ff && !req_ready)

endmodule

### tb/led_strip_pixel_store_core_tb.sv
// Self-checking testbench for the LED strip pixel store core.
module led_strip_pixel_store_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lsps_pkg::*;

   localparam int MAX_PIXELS = 256;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;
   localparam int HOLD_AFTER_OPS = 80;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [INDEX_W-1:0] pixel_index;
      logic [STEPS_W-1:0] shift_steps;
      logic [BYTE_W-1:0]  red;
      logic [BYTE_W-1:0]  green;
      logic [BYTE_W-1:0]  blue;
   } pixel_op_type;

   typedef struct packed {
      logic              status;
      logic [BYTE_W-1:0] first_byte;
      logic [BYTE_W-1:0] second_byte;
      logic [BYTE_W-1:0] third_byte;
   } pixel_rsp_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CFG_INDEX_W-1:0] csr_index;
   logic [CFG_DATA_W-1:0] csr_wdata;
   logic idle_en;

   lsps_req_if req_chan();
   lsps_rsp_if rsp_chan();

   led_strip_pixel_store_core #(
      .MAX_PIXELS(MAX_PIXELS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   logic [PIXEL_W-1:0] pixel_mem [MAX_PIXELS] = '{default: '0};
   int cfg_count = 0;
   bit cfg_grb = 1'b1;

   pixel_op_type op_q[$];
   pixel_rsp_type pixel_rsp_q[$];
   pixel_op_type cur_op;
   int send_gap;
   int stall_left;
   int hold_left;
   bit hold_done;
   int ops_accepted;
   int mismatches = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("led_strip_pixel_store_core verification failed");
      $finish;
   end

   function automatic pixel_rsp_type apply_pixel_op(pixel_op_type op);
      pixel_rsp_type rsp;
      logic [PIXEL_W-1:0] snap [MAX_PIXELS];
      logic [PIXEL_W-1:0] fill;
      int n;
      rsp = '0;
      snap = pixel_mem;
      fill = {op.red, op.green, op.blue};
      n = (cfg_count > MAX_PIXELS) ? MAX_PIXELS : cfg_count;
      case (op.func)
         FUNC_SET: begin
            if (op.pixel_index < n) begin
               pixel_mem[op.pixel_index] = cfg_grb ? {op.green, op.red, op.blue} : fill;
            end else begin
               rsp.status = 1'b1;
            end
         end
         FUNC_GET: begin
            if (op.pixel_index < n) begin
               {rsp.first_byte, rsp.second_byte, rsp.third_byte} = pixel_mem[op.pixel_index];
            end else begin
               rsp.status = 1'b1;
            end
         end
         FUNC_CLEAR: begin
            foreach (pixel_mem[i]) pixel_mem[i] = '0;
         end
         FUNC_ROTL: begin
            for (int i = 0; i < n; i++) pixel_mem[i] = snap[(i + 1) % n];
         end
         FUNC_ROTR: begin
            for (int i = 0; i < n; i++) pixel_mem[i] = snap[(i + n - 1) % n];
         end
         FUNC_SHL: begin
            if (op.shift_steps == 0 || op.shift_steps > n) begin
               rsp.status = 1'b1;
            end else begin
               for (int i = 0; i < n; i++) begin
                  pixel_mem[i] = (i + op.shift_steps < n) ? snap[i + op.shift_steps] : fill;
               end
            end
         end
         FUNC_SHR: begin
            if (op.shift_steps == 0 || op.shift_steps > n) begin
               rsp.status = 1'b1;
            end else begin
               for (int i = 0; i < n; i++) begin
                  pixel_mem[i] = (i >= op.shift_steps) ? snap[i - op.shift_steps] : fill;
               end
            end
         end
         default: begin
         end
      endcase
      return rsp;
   endfunction

   function automatic pixel_op_type random_pixel_op(int n);
      pixel_op_type op;
      int pick;
      int sel;
      pick = $urandom_range(0, 99);
      if (pick < 30) op.func = FUNC_SET;
      else if (pick < 60) op.func = FUNC_GET;
      else if (pick < 63) op.func = FUNC_CLEAR;
      else if (pick < 71) op.func = FUNC_ROTL;
      else if (pick < 79) op.func = FUNC_ROTR;
      else if (pick < 89) op.func = FUNC_SHL;
      else if (pick < 99) op.func = FUNC_SHR;
      else op.func = FUNC_UNUSED;
      if (n > 0 && $urandom_range(0, 9) < 8) op.pixel_index = INDEX_W'($urandom_range(0, n - 1));
      else op.pixel_index = INDEX_W'($urandom_range(0, 255));
      sel = $urandom_range(0, 9);
      if (n > 0 && sel < 8) op.shift_steps = STEPS_W'($urandom_range(1, n));
      else if (sel == 8) op.shift_steps = STEPS_W'($urandom_range(0, 1) ? n + 1 : 0);
      else op.shift_steps = STEPS_W'($urandom_range(0, 511));
      op.red = BYTE_W'($urandom_range(0, 255));
      op.green = BYTE_W'($urandom_range(0, 255));
      op.blue = BYTE_W'($urandom_range(0, 255));
      return op;
   endfunction

   task automatic push_op(logic [FUNC_W-1:0] func, int index, int steps, int red, int green,
                          int blue);
      pixel_op_type op;
      op.func = func;
      op.pixel_index = INDEX_W'(index);
      op.shift_steps = STEPS_W'(steps);
      op.red = BYTE_W'(red);
      op.green = BYTE_W'(green);
      op.blue = BYTE_W'(blue);
      op_q.push_back(op);
   endtask

   task automatic write_csr(csr_index_type index, int value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[CFG_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_PIXEL_COUNT: cfg_count = value & 'h1FF;
         CSR_GRB_ORDER: cfg_grb = value[0];
         default: begin
         end
      endcase
   endtask

   task automatic drain_ops();
      do @(posedge clock);
      while (op_q.size() != 0 || req_chan.valid || pixel_rsp_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.func <= FUNC_SET;
         req_chan.pixel_index <= '0;
         req_chan.shift_steps <= '0;
         req_chan.red_in <= '0;
         req_chan.green_in <= '0;
         req_chan.blue_in <= '0;
         send_gap <= 0;
         ops_accepted <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            pixel_rsp_q.push_back(apply_pixel_op(cur_op));
            ops_accepted <= ops_accepted + 1;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
               req_chan.valid <= 1'b0;
            end else if (op_q.size() != 0) begin
               cur_op = op_q.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.func <= cur_op.func;
               req_chan.pixel_index <= cur_op.pixel_index;
               req_chan.shift_steps <= cur_op.shift_steps;
               req_chan.red_in <= cur_op.red;
               req_chan.green_in <= cur_op.green;
               req_chan.blue_in <= cur_op.blue;
               if (idle_en && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 11);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && ops_accepted >= HOLD_AFTER_OPS) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      pixel_rsp_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pixel_rsp_q.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected transaction, expected none actual status %0d",
                        $time, rsp_chan.status);
            end else begin
               want = pixel_rsp_q.pop_front();
               check_field("status", want.status, rsp_chan.status);
               check_field("first_byte", want.first_byte, rsp_chan.first_byte);
               check_field("second_byte", want.second_byte, rsp_chan.second_byte);
               check_field("third_byte", want.third_byte, rsp_chan.third_byte);
            end
         end
         if (hold_left != 0) begin
            rsp_chan.ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_chan.ready <= 1'b0;
         end else if (idle_en && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 10);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      int phase_count[11] = '{16, 1, 2, 5, 8, 3, 256, 511, 0, 12, 7};
      int phase_grb[11] = '{1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 1};
      int phase_ops[11] = '{300, 150, 150, 200, 200, 150, 40, 20, 40, 300, 350};
      int phase_idle[11] = '{1, 1, 0, 1, 1, 1, 1, 1, 1, 1, 0};
      int n;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_PIXEL_COUNT;
      csr_wdata = '0;
      idle_en = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration: no active pixels, GRB order.
      push_op(FUNC_SET, 0, 0, 1, 2, 3);
      push_op(FUNC_GET, 0, 0, 0, 0, 0);
      push_op(FUNC_ROTL, 0, 0, 0, 0, 0);
      push_op(FUNC_ROTR, 0, 0, 0, 0, 0);
      push_op(FUNC_SHL, 0, 1, 9, 9, 9);
      push_op(FUNC_SHR, 0, 0, 9, 9, 9);
      drain_ops();

      write_csr(CSR_PIXEL_COUNT, MAX_PIXELS);
      push_op(FUNC_SET, 255, 0, 'hFF, 'h00, 'hAA);
      push_op(FUNC_SET, 0, 0, 'h00, 'hFF, 'h55);
      push_op(FUNC_GET, 255, 0, 0, 0, 0);
      push_op(FUNC_GET, 0, 0, 0, 0, 0);
      push_op(FUNC_ROTL, 0, 0, 0, 0, 0);
      push_op(FUNC_GET, 255, 0, 0, 0, 0);
      push_op(FUNC_ROTR, 0, 0, 0, 0, 0);
      push_op(FUNC_GET, 0, 0, 0, 0, 0);
      push_op(FUNC_SHL, 0, 256, 'h01, 'h80, 'hFE);
      push_op(FUNC_GET, 128, 0, 0, 0, 0);
      push_op(FUNC_SHR, 0, 257, 0, 0, 0);
      push_op(FUNC_SHL, 0, 0, 0, 0, 0);
      push_op(FUNC_SHR, 0, 511, 0, 0, 0);
      push_op(FUNC_SET, 17, 0, 'hFF, 'hFF, 'hFF);
      push_op(FUNC_SHR, 0, 1, 0, 0, 0);
      push_op(FUNC_GET, 18, 0, 0, 0, 0);
      push_op(FUNC_UNUSED, 255, 511, 'hFF, 'hFF, 'hFF);
      push_op(FUNC_CLEAR, 0, 0, 0, 0, 0);
      push_op(FUNC_GET, 18, 0, 0, 0, 0);
      drain_ops();

      write_csr(CSR_GRB_ORDER, 0);
      push_op(FUNC_SET, 3, 0, 'hAB, 'hCD, 'hEF);
      push_op(FUNC_GET, 3, 0, 0, 0, 0);
      push_op(FUNC_SHL, 0, 255, 'h11, 'h22, 'h33);
      push_op(FUNC_GET, 0, 0, 0, 0, 0);
      push_op(FUNC_GET, 255, 0, 0, 0, 0);
      drain_ops();

      foreach (phase_count[p]) begin
         write_csr(CSR_PIXEL_COUNT, phase_count[p]);
         write_csr(CSR_GRB_ORDER, phase_grb[p]);
         idle_en <= phase_idle[p];
         n = (phase_count[p] > MAX_PIXELS) ? MAX_PIXELS : phase_count[p];
         repeat (phase_ops[p]) op_q.push_back(random_pixel_op(n));
         drain_ops();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("led_strip_pixel_store_core verification clean");
      end else begin
         $display("led_strip_pixel_store_core verification failed");
      end
      $finish;
   end

endmodule
